FILE: sv/rvmx_pkg.sv
`timescale 1ns / 1ps
package rvmx_pkg;
  localparam int RegisterCountDef = 16;
  localparam int DataW = 64;
  localparam int ModeW = 5;
  localparam int IdxW = 4;
  localparam int AddrW = 16;

  typedef enum logic [ModeW-1:0] {
    OP_NOP = 5'd0, OP_LDC = 5'd1, OP_MOV = 5'd2, OP_LAND = 5'd3, OP_LOR = 5'd4,
    OP_LNOT = 5'd5, OP_ADD = 5'd6, OP_SUB = 5'd7, OP_MUL = 5'd8, OP_DIV = 5'd9,
    OP_MOD = 5'd10, OP_SHL = 5'd11, OP_SHR = 5'd12, OP_BAND = 5'd13, OP_BOR = 5'd14,
    OP_BXOR = 5'd15, OP_EQ = 5'd16, OP_NE = 5'd17, OP_GT = 5'd18, OP_GE = 5'd19,
    OP_LT = 5'd20, OP_LE = 5'd21, OP_CBR = 5'd22, OP_JMP = 5'd23, OP_RET = 5'd24
  } op_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [IdxW-1:0] dest_index;
    logic [IdxW-1:0] left_index;
    logic [IdxW-1:0] right_index;
    logic signed [DataW-1:0] constant_value;
    logic [AddrW-1:0] branch_target;
  } in_item_t;

  typedef struct packed {
    logic write_enable;
    logic [IdxW-1:0] write_index;
    logic signed [DataW-1:0] write_value;
    logic taken;
    logic [AddrW-1:0] next_address;
    logic returned;
    logic signed [DataW-1:0] return_value;
    logic fault;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture item, read operands
    logic start;    // operands ready, begin execute
    logic div_step;
    logic finish;   // build result, write back
  } cmd_t;

  typedef struct packed {
    logic is_div;
    logic div_done;
  } sts_t;
endpackage

FILE: sv/rvmx_if.sv
`timescale 1ns / 1ps
interface rvmx_in_if import rvmx_pkg::*; ();
  logic valid;
  logic ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface rvmx_out_if import rvmx_pkg::*; ();
  logic valid;
  logic ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: sv/rvmx_ctrl.sv
`timescale 1ns / 1ps
module rvmx_ctrl import rvmx_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_free,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_READ = 5'b00010, S_EXEC = 5'b00100,
    S_DIV = 5'b01000, S_DONE = 5'b10000
  } state_t;
  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.start = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = sts.is_div ? S_DIV : S_DONE;
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_DONE;
      end
      S_DONE: if (out_free) begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

FILE: sv/rvmx_dp.sv
`timescale 1ns / 1ps
module rvmx_dp import rvmx_pkg::*; #(
  parameter int REGISTER_COUNT = RegisterCountDef
) (
  input  logic clk,
  input  logic rst_n,
  input  in_item_t in_data,
  input  cmd_t cmd,
  output sts_t sts,
  output logic out_valid,
  input  logic out_ready,
  output logic out_free,
  output out_item_t out_data
);
  localparam int SelW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int CntW = $clog2(DataW + 1);

  logic [DataW-1:0] rf_r [REGISTER_COUNT];
  in_item_t item_r;
  logic [DataW-1:0] l_r, r_r, res_r;
  logic [SelW-1:0] dsel;
  logic fault_r;

  // divider state: restoring, one quotient bit per cycle
  logic [DataW-1:0] quo_r, rem_r;
  logic [CntW-1:0] cnt_r;
  logic neg_q_r, neg_r_r;

  // index wrap as a small constant table
  function automatic logic [SelW-1:0] sel(input logic [IdxW-1:0] i);
    sel = '0;
    for (int k = 0; k < (1 << IdxW); k++) begin
      if (i == IdxW'(k)) sel = SelW'(k % REGISTER_COUNT);
    end
  endfunction

  assign dsel = sel(item_r.dest_index);
  assign sts.is_div = (item_r.mode == OP_DIV) || (item_r.mode == OP_MOD);
  assign sts.div_done = (cnt_r == CntW'(0));

  logic lt, lz, rz;
  assign lt = $signed(l_r) < $signed(r_r);
  assign lz = (l_r == '0);
  assign rz = (r_r == '0);

  logic [DataW-1:0] alu;
  always_comb begin
    alu = '0;
    case (item_r.mode)
      OP_LDC:  alu = item_r.constant_value;
      OP_MOV:  alu = l_r;
      OP_LAND: alu = DataW'(!lz && !rz);
      OP_LOR:  alu = DataW'(!lz || !rz);
      OP_LNOT: alu = DataW'(lz);
      OP_ADD:  alu = l_r + r_r;
      OP_SUB:  alu = l_r - r_r;
      OP_SHL:  alu = l_r << r_r[5:0];
      OP_SHR:  alu = DataW'($signed(l_r) >>> r_r[5:0]);
      OP_BAND: alu = l_r & r_r;
      OP_BOR:  alu = l_r | r_r;
      OP_BXOR: alu = l_r ^ r_r;
      OP_EQ:   alu = DataW'(l_r == r_r);
      OP_NE:   alu = DataW'(l_r != r_r);
      OP_GT:   alu = DataW'(!lt && (l_r != r_r));
      OP_GE:   alu = DataW'(!lt);
      OP_LT:   alu = DataW'(lt);
      OP_LE:   alu = DataW'(lt || (l_r == r_r));
      default: alu = '0;
    endcase
  end

  // 64x64 product (low 64 bits) from three 32x32 partials, registered
  logic [DataW-1:0] p_ll_r, p_x_r;
  logic [DataW:0] trial;
  assign trial = {rem_r, quo_r[DataW-1]} - {1'b0, r_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      l_r <= rf_r[sel(in_data.left_index)];
      r_r <= rf_r[sel(in_data.right_index)];
    end
    if (cmd.start) begin
      p_ll_r <= l_r[31:0] * r_r[31:0];
      p_x_r <= {l_r[31:0] * r_r[63:32] + l_r[63:32] * r_r[31:0], 32'd0};
      neg_q_r <= l_r[DataW-1] ^ r_r[DataW-1];
      neg_r_r <= l_r[DataW-1];
      quo_r <= l_r[DataW-1] ? -l_r : l_r;
      rem_r <= '0;
      cnt_r <= CntW'(DataW);
      fault_r <= rz && sts.is_div;
      r_r <= r_r[DataW-1] ? -r_r : r_r;
      res_r <= alu;
    end else if (item_r.mode == OP_MUL && cnt_r == CntW'(DataW) && !cmd.div_step
                 && !cmd.finish && !cmd.load) begin
      res_r <= p_ll_r + p_x_r;
    end
    if (cmd.div_step && !sts.div_done) begin
      if (!trial[DataW]) begin
        rem_r <= trial[DataW-1:0];
        quo_r <= {quo_r[DataW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DataW-2:0], quo_r[DataW-1]};
        quo_r <= {quo_r[DataW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - CntW'(1);
    end
  end

  // result assembly
  out_item_t res;
  logic [DataW-1:0] v;
  logic we;
  always_comb begin
    res = '0;
    we = 1'b0;
    v = res_r;
    case (item_r.mode)
      OP_DIV: v = fault_r ? '0 : (neg_q_r ? -quo_r : quo_r);
      OP_MOD: v = fault_r ? '0 : (neg_r_r ? -rem_r : rem_r);
      default: v = res_r;
    endcase
    case (item_r.mode)
      OP_CBR: begin
        res.taken = (l_r != '0);
        res.next_address = res.taken ? item_r.branch_target : '0;
      end
      OP_JMP: begin
        res.taken = 1'b1;
        res.next_address = item_r.branch_target;
      end
      OP_RET: begin
        res.returned = 1'b1;
        res.return_value = l_r;
      end
      default: we = (item_r.mode != OP_NOP) && (item_r.mode < OP_CBR);
    endcase
    res.write_enable = we;
    res.write_index = we ? IdxW'(dsel) : '0;
    res.write_value = we ? v : '0;
    res.fault = fault_r;
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      for (int i = 0; i < REGISTER_COUNT; i++) rf_r[i] <= '0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
        out_data <= res;
        if (we) rf_r[dsel] <= v;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

FILE: sv/register_vm_execute_unit_top.sv
`timescale 1ns / 1ps
// Executes one decoded instruction per beat against a register file of
// REGISTER_COUNT 64-bit registers, cleared by reset. Each input beat yields
// one result beat. Ordinary operations run operand read, execute, multiply
// partial sum and write back in turn; the result register is loaded at write
// back. Div and mod run a restoring divider one quotient bit a cycle, and
// their result is registered at write back once the divider is done. A new
// beat is taken the cycle after the previous result is registered; a result
// not yet taken holds off the next write back.
module register_vm_execute_unit_top import rvmx_pkg::*; #(
  parameter int REGISTER_COUNT = RegisterCountDef
) (
  input logic clk,
  input logic rst_n,
  rvmx_in_if.sink in_ch,
  rvmx_out_if.source out_ch
);
  cmd_t cmd;
  sts_t sts;
  logic out_free;

  rvmx_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_free(out_free), .sts(sts), .cmd(cmd)
  );

  rvmx_dp #(.REGISTER_COUNT(REGISTER_COUNT)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_ch.data), .cmd(cmd), .sts(sts),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_free(out_free),
    .out_data(out_ch.data)
  );

  a_one_hot_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.start, cmd.div_step, cmd.finish})) else $error("cmd");
  a_start_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.start) else $error("start");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !in_ch.ready) else $error("busy");
endmodule
